[src/thef_pkg.sv]
`default_nettype none
package thef_pkg;
  localparam int unsigned HeaderBytes = 48;
  localparam int unsigned MaxDimDefault = 1024;
  localparam int unsigned FillW = 6;
  localparam int unsigned SkipW = 35;

  typedef struct packed {
    logic hdr_ok;
    logic len_zero;
    logic len_busy;
  } thef_status_t;

  typedef struct packed {
    logic len_start;
  } thef_cmd_t;

  function automatic logic [7:0] fix_byte(input logic [7:0] b, input logic [5:0] idx,
                                          input logic [7:0] partner);
    logic [7:0] r;
    r = b;
    if (idx >= 6'h20 && idx < 6'h28) begin
      r = partner;
    end else if (idx == 6'h2A) begin
      r = {b[1:0], b[7:2]};
    end else if (idx >= 6'h2B && idx <= 6'h2E) begin
      r = {b[3:0], b[7:4]};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[src/thef_ram.sv]
`default_nettype none
module thef_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[src/thef_len.sv]
`default_nettype none
// Sequential data-length unit: one multiply per cycle.
module thef_len (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] mw_i,
  input  wire logic [15:0] mh_i,
  input  wire logic [15:0] aw_i,
  input  wire logic [15:0] ah_i,
  input  wire logic [7:0]  xt_i,
  input  wire logic [7:0]  fmt_i,
  input  wire logic [7:0]  dep_i,
  output logic             busy_o,
  output logic [thef_pkg::SkipW-1:0] len_o
);
  typedef enum logic [2:0] {LIdle, LMain, LMip, LScale, LAux, LDone} lstate_e;
  lstate_e st_q;
  logic [15:0] w_q, h_q;
  logic [31:0] acc_q;
  logic [4:0]  sh_q;
  logic [thef_pkg::SkipW-1:0] tot_q;
  logic [3:0] dm, da;
  logic [15:0] wd, hd;
  logic [4:0] thr;
  logic [31:0] prod, scaled;

  assign dm = dep_i[3:0];
  assign da = dep_i[7:4];
  assign wd = w_q >> sh_q;
  assign hd = h_q >> sh_q;
  assign prod = 32'(wd) * 32'(hd);

  function automatic logic [31:0] scl(input logic [31:0] s, input logic [3:0] d);
    logic [31:0] r;
    case (d)
      4'd0: r = s >> 1;
      4'd2: r = s << 1;
      4'd3: r = s << 2;
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] pal(input logic [3:0] f, input logic [3:0] d);
    logic [9:0] r;
    r = '0;
    if (f == 4'd2) begin
      r = (d == 4'd1) ? 10'h200 : 10'h020;
    end
    return r;
  endfunction

  always_comb begin
    thr = 5'(5'd16 >> dm[1:0]);
    scaled = scl(acc_q, dm);
  end

  assign busy_o = (st_q != LIdle) && (st_q != LDone);
  assign len_o = tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LIdle;
      w_q <= '0;
      h_q <= '0;
      acc_q <= '0;
      sh_q <= '0;
      tot_q <= '0;
    end else begin
      case (st_q)
        LIdle, LDone: begin
          if (start_i) begin
            w_q <= mw_i;
            h_q <= mh_i;
            sh_q <= '0;
            st_q <= LMain;
          end
        end
        LMain: begin
          acc_q <= prod;
          sh_q <= 5'd1;
          st_q <= (xt_i == 8'd1 && dm <= 4'd3) ? LMip : LScale;
        end
        LMip: begin
          if (sh_q <= 5'd17 && wd >= 16'(thr) && hd != 16'd0) begin
            acc_q <= acc_q + prod;
            sh_q <= sh_q + 5'd1;
          end else begin
            st_q <= LScale;
          end
        end
        LScale: begin
          tot_q <= 35'(scaled) + 35'(pal(fmt_i[3:0], dm));
          w_q <= aw_i;
          h_q <= ah_i;
          sh_q <= '0;
          st_q <= (xt_i == 8'd3) ? LAux : LDone;
        end
        LAux: begin
          tot_q <= tot_q + 35'(scl(prod, da)) + 35'(pal(fmt_i[7:4], da));
          st_q <= LDone;
        end
        default: st_q <= LIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/thef_datapath.sv]
`default_nettype none
module thef_datapath #(
  parameter int unsigned MaxDim = thef_pkg::MaxDimDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire logic [5:0]  waddr_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic        clr_i,
  input  wire logic [5:0]  raddr_i,
  input  wire logic        fix_i,
  input  wire thef_pkg::thef_cmd_t cmd_i,
  output thef_pkg::thef_status_t   sts_o,
  output logic [7:0]       rdata_o,
  output logic [thef_pkg::SkipW-1:0] len_o
);
  logic [7:0] rd, rd2;
  logic [5:0] ridx_q, paddr;
  logic name_good_q, name_ended_q;
  logic [7:0] b20_q, b21_q, b22_q, b23_q, b24_q, b25_q, b26_q, b27_q, b29_q, b2b_q, b2c_q;
  logic [15:0] mw, mh;
  logic busy;

  assign paddr = raddr_i ^ 6'd1;
  thef_ram #(.Width(8), .Depth(thef_pkg::HeaderBytes)) u_ram (
    .clk_i, .we_i(wr_i), .waddr_i, .wdata_i, .raddr_i, .rdata_o(rd));
  thef_ram #(.Width(8), .Depth(thef_pkg::HeaderBytes)) u_ram2 (
    .clk_i, .we_i(wr_i), .waddr_i, .wdata_i, .raddr_i(paddr), .rdata_o(rd2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_good_q <= 1'b1;
      name_ended_q <= 1'b0;
      ridx_q <= '0;
    end else begin
      ridx_q <= raddr_i;
      if (clr_i) begin
        name_good_q <= 1'b1;
        name_ended_q <= 1'b0;
      end else if (wr_i && waddr_i < 6'd32 && !name_ended_q) begin
        if (wdata_i == 8'h00) name_ended_q <= 1'b1;
        else if (wdata_i < 8'h20 || wdata_i > 8'h7E) name_good_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      case (waddr_i)
        6'h20: b20_q <= wdata_i;
        6'h21: b21_q <= wdata_i;
        6'h22: b22_q <= wdata_i;
        6'h23: b23_q <= wdata_i;
        6'h24: b24_q <= wdata_i;
        6'h25: b25_q <= wdata_i;
        6'h26: b26_q <= wdata_i;
        6'h27: b27_q <= wdata_i;
        6'h29: b29_q <= wdata_i;
        6'h2B: b2b_q <= wdata_i;
        6'h2C: b2c_q <= wdata_i;
        default: ;
      endcase
    end
  end

  assign mw = {b22_q, b23_q};
  assign mh = {b26_q, b27_q};

  thef_len u_len (
    .clk_i, .rst_ni, .start_i(cmd_i.len_start),
    .mw_i(mw), .mh_i(mh), .aw_i({b20_q, b21_q}), .ah_i({b24_q, b25_q}),
    .xt_i(b29_q), .fmt_i(b2b_q), .dep_i(b2c_q), .busy_o(busy), .len_o);

  assign sts_o.hdr_ok = name_good_q && mw != 16'd0 && mh != 16'd0 &&
                        mw <= 16'(MaxDim) && mh <= 16'(MaxDim);
  assign sts_o.len_zero = (len_o == '0);
  assign sts_o.len_busy = busy;
  assign rdata_o = fix_i ? thef_pkg::fix_byte(rd, ridx_q, rd2) : rd;
endmodule
`default_nettype wire

[src/thef_ctrl.sv]
`default_nettype none
module thef_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_fire_i,
  input  wire logic [7:0]  s_data_i,
  input  wire logic        s_last_i,
  output logic             s_ready_o,
  output logic [7:0]       m_data_o,
  output logic             m_last_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic             wr_o,
  output logic [5:0]       waddr_o,
  output logic             clr_o,
  output logic [5:0]       raddr_o,
  output logic             fix_o,
  output thef_pkg::thef_cmd_t cmd_o,
  input  wire thef_pkg::thef_status_t sts_i,
  input  wire logic [7:0]  rdata_i,
  input  wire logic [thef_pkg::SkipW-1:0] len_i
);
  typedef enum logic [2:0] {SCollect, SLen, SEmit, SSkip, SPass} state_e;
  state_e st_q, after_q;
  logic [5:0] fill_q, cnt_q, nout_q;
  logic [thef_pkg::SkipW-1:0] skip_q;
  logic ok_q, lastpend_q, rv_q, ob_v_q, ob_last_q;
  logic [7:0] ob_q;
  logic ob_free, emit_go;

  assign ob_free = !ob_v_q || m_ready_i;
  assign m_valid_o = ob_v_q;
  assign m_data_o = ob_q;
  assign m_last_o = ob_last_q;
  assign s_ready_o = ((st_q == SCollect) || ((st_q == SSkip || st_q == SPass) && ob_free))
                     && !rv_q;
  assign wr_o = s_fire_i && st_q == SCollect;
  assign waddr_o = fill_q;
  assign fix_o = ok_q;
  assign emit_go = st_q == SEmit && ob_free && !rv_q && cnt_q < nout_q;
  assign raddr_o = cnt_q;
  assign cmd_o.len_start = wr_o && fill_q == 6'(thef_pkg::HeaderBytes - 1);
  assign clr_o = cmd_o.len_start || (wr_o && s_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SCollect;
      after_q <= SCollect;
      fill_q <= '0;
      cnt_q <= '0;
      nout_q <= '0;
      skip_q <= '0;
      ok_q <= 1'b0;
      lastpend_q <= 1'b0;
      rv_q <= 1'b0;
      ob_v_q <= 1'b0;
      ob_last_q <= 1'b0;
      ob_q <= '0;
    end else begin
      if (m_ready_i) ob_v_q <= 1'b0;
      rv_q <= 1'b0;
      case (st_q)
        SCollect: begin
          if (s_fire_i) begin
            fill_q <= fill_q + 6'd1;
            lastpend_q <= s_last_i;
            if (fill_q == 6'(thef_pkg::HeaderBytes - 1)) begin
              ok_q <= sts_i.hdr_ok;
              st_q <= SLen;
              nout_q <= 6'(thef_pkg::HeaderBytes);
            end else if (s_last_i) begin
              ok_q <= 1'b0;
              nout_q <= fill_q + 6'd1;
              cnt_q <= '0;
              st_q <= SEmit;
              after_q <= SCollect;
            end
          end
        end
        SLen: begin
          if (!sts_i.len_busy && !cmd_o.len_start && fill_q == '0) begin
            cnt_q <= '0;
            st_q <= SEmit;
            if (!ok_q) after_q <= SPass;
            else if (sts_i.len_zero) after_q <= SCollect;
            else after_q <= SSkip;
            skip_q <= len_i;
          end
          fill_q <= '0;
        end
        SEmit: begin
          if (emit_go) rv_q <= 1'b1;
          if (rv_q) begin
            ob_v_q <= 1'b1;
            ob_q <= rdata_i;
            ob_last_q <= lastpend_q && (cnt_q + 6'd1 == nout_q);
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q + 6'd1 == nout_q) begin
              fill_q <= '0;
              if (lastpend_q) begin
                st_q <= SCollect;
                lastpend_q <= 1'b0;
                ok_q <= 1'b0;
              end else begin
                st_q <= after_q;
              end
            end
          end
        end
        SSkip, SPass: begin
          if (s_fire_i) begin
            ob_v_q <= 1'b1;
            ob_q <= s_data_i;
            ob_last_q <= s_last_i;
            if (s_last_i) begin
              st_q <= SCollect;
              fill_q <= '0;
            end else if (st_q == SSkip) begin
              skip_q <= skip_q - 35'd1;
              if (skip_q == 35'd1) begin
                st_q <= SCollect;
                fill_q <= '0;
              end
            end
          end
        end
        default: st_q <= SPass;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/texture_header_endian_fixup.sv]
// Texture header endian fix-up.
// Slave channel s_axis_*: one buffer byte per transaction, tlast on the final byte.
// Master channel m_axis_*: the same bytes in order, tlast on the final byte.
// Each 48-byte header is collected into two small RAMs while the validity check runs.
// After the last header byte a length unit computes the data size, one multiply
// per cycle; the controller waits for it, longer with mipmaps (one multiply per
// mipmap level) or an aux raster.
// The header is then read back and sent one byte at a time, each read ending
// before the next starts, fixed up when valid. Texture data and everything after
// a bad header pass at one byte per cycle while the receiver is ready, through
// a single output register.
// A stalled receiver holds the output register and back-pressures the input.
// Reset (rst_ni low) empties the block and starts collecting a header; the
// controller also returns to collecting once a tlast byte enters the output register.
`default_nettype none
module texture_header_endian_fixup #(
  parameter int unsigned MaxDim = thef_pkg::MaxDimDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tlast,   // end_of_buffer
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic            m_axis_tlast    // out_last
);
  logic wr, clr, fix, s_fire;
  logic [5:0] waddr, raddr;
  logic [7:0] rdata;
  logic [thef_pkg::SkipW-1:0] len;
  thef_pkg::thef_cmd_t cmd;
  thef_pkg::thef_status_t sts;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  thef_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_fire_i(s_fire), .s_data_i(s_axis_tdata), .s_last_i(s_axis_tlast),
    .s_ready_o(s_axis_tready), .m_data_o(m_axis_tdata), .m_last_o(m_axis_tlast),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .wr_o(wr), .waddr_o(waddr),
    .clr_o(clr), .raddr_o(raddr), .fix_o(fix), .cmd_o(cmd), .sts_i(sts),
    .rdata_i(rdata), .len_i(len));

  thef_datapath #(.MaxDim(MaxDim)) u_dp (
    .clk_i, .rst_ni, .wr_i(wr), .waddr_i(waddr), .wdata_i(s_axis_tdata), .clr_i(clr),
    .raddr_i(raddr), .fix_i(fix), .cmd_i(cmd), .sts_o(sts), .rdata_o(rdata), .len_o(len));
endmodule
`default_nettype wire

[src/thef_checker.sv]
`default_nettype none
module thef_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("tlast changed while stalled");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
    else $error("handshake signal unknown");
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output after end of buffer");
endmodule

bind texture_header_endian_fixup thef_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast);
`default_nettype wire
